FILE: design/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types, step codes and the control store of the best-fit allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam int STEP_BITS = 3;

    localparam logic [STEP_BITS-1:0] S_FETCH    = 3'd0;
    localparam logic [STEP_BITS-1:0] S_DISPATCH = 3'd1;
    localparam logic [STEP_BITS-1:0] S_SCAN     = 3'd2;
    localparam logic [STEP_BITS-1:0] S_ALLOC_WB = 3'd3;
    localparam logic [STEP_BITS-1:0] S_LOAD     = 3'd4;
    localparam logic [STEP_BITS-1:0] S_EMIT     = 3'd5;

    localparam logic [1:0] H_NONE     = 2'd0;
    localparam logic [1:0] H_NO_IN    = 2'd1;
    localparam logic [1:0] H_SCAN     = 2'd2;
    localparam logic [1:0] H_OUT_BUSY = 2'd3;

    localparam logic [1:0] J_NONE   = 2'd0;
    localparam logic [1:0] J_ALWAYS = 2'd1;
    localparam logic [1:0] J_LOAD   = 2'd2;

    localparam int CFG_BITS = 5;
    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic        operation;
        logic [3:0]  segment_index;
        logic [15:0] size_kb;
    } in_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_segment;
        logic [15:0] remaining_kb;
    } out_t;

    typedef struct packed {
        logic                 in_take;
        logic                 scan_init;
        logic                 scan_step;
        logic                 alloc_wb;
        logic                 load_wr;
        logic                 emit;
        logic [1:0]           hold;
        logic [1:0]           jump;
        logic [STEP_BITS-1:0] target;
    } uop_t;

    typedef struct packed {
        logic in_valid;
        logic is_load;
        logic scan_busy;
        logic out_busy;
    } status_t;

    function automatic uop_t ucode(input logic [STEP_BITS-1:0] pc);
        uop_t u;
        u = '0;
        case (pc)
            S_FETCH:
            begin
                u.in_take = 1'b1;
                u.hold    = H_NO_IN;
            end
            S_DISPATCH:
            begin
                u.scan_init = 1'b1;
                u.jump      = J_LOAD;
                u.target    = S_LOAD;
            end
            S_SCAN:
            begin
                u.scan_step = 1'b1;
                u.hold      = H_SCAN;
            end
            S_ALLOC_WB:
            begin
                u.alloc_wb = 1'b1;
                u.jump     = J_ALWAYS;
                u.target   = S_EMIT;
            end
            S_LOAD:
            begin
                u.load_wr = 1'b1;
            end
            S_EMIT:
            begin
                u.emit   = 1'b1;
                u.hold   = H_OUT_BUSY;
                u.jump   = J_ALWAYS;
                u.target = S_FETCH;
            end
            default:
            begin
                u.jump   = J_ALWAYS;
                u.target = S_FETCH;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: design/bfsa_ram.sv
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bfsa_sequencer.sv
// ----------------------------------------------------------------------------
// bfsa_sequencer
// Step counter over the control store, with hold and jump conditions.
// ----------------------------------------------------------------------------
module bfsa_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  bfsa_pkg::status_t status,
    output bfsa_pkg::uop_t    uop
);
    import bfsa_pkg::*;

    logic [STEP_BITS-1:0] pc_reg;
    logic [STEP_BITS-1:0] pc_next;
    logic                 hold_now;
    logic                 jump_now;

    assign uop = ucode(pc_reg);

    always_comb
    begin
        case (uop.hold)
            H_NONE:     hold_now = 1'b0;
            H_NO_IN:    hold_now = !status.in_valid;
            H_SCAN:     hold_now = status.scan_busy;
            H_OUT_BUSY: hold_now = status.out_busy;
            default:    hold_now = 1'b0;
        endcase
        case (uop.jump)
            J_NONE:   jump_now = 1'b0;
            J_ALWAYS: jump_now = 1'b1;
            J_LOAD:   jump_now = status.is_load;
            default:  jump_now = 1'b0;
        endcase
        if (hold_now)
        begin
            pc_next = pc_reg;
        end
        else if (jump_now)
        begin
            pc_next = uop.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: design/bfsa_datapath.sv
// ----------------------------------------------------------------------------
// bfsa_datapath
// Item latch, free-space store, best-fit compare unit and result register.
// ----------------------------------------------------------------------------
module bfsa_datapath #(
    parameter int NUM_SEGMENTS = 16,
    parameter int SIZE_BITS    = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfsa_pkg::uop_t          uop,
    output bfsa_pkg::status_t       status,
    input  logic [4:0]              active_segments,
    input  logic                    in_valid,
    input  bfsa_pkg::in_t           in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output bfsa_pkg::out_t          out_data
);
    import bfsa_pkg::*;

    localparam int IW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int CW = $clog2(NUM_SEGMENTS + 1);

    logic                 op_reg;
    logic [3:0]           idx_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [31:0]          size_wide;

    logic [CW-1:0]        scan_i_reg;
    logic [CW-1:0]        n_reg;
    logic                 cmp_vld_reg;
    logic [IW-1:0]        cmp_idx_reg;
    logic                 found_reg;
    logic [IW-1:0]        best_reg;
    logic [SIZE_BITS-1:0] best_rem_reg;

    logic [NUM_SEGMENTS-1:0] seg_vld_reg;
    logic                    rd_vld_reg;
    logic                    rd_en;
    logic [IW-1:0]           rd_addr;
    logic [SIZE_BITS-1:0]    rd_data;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [SIZE_BITS-1:0]    wr_data;

    logic [SIZE_BITS-1:0] free_kb;
    logic [SIZE_BITS-1:0] rem_kb;
    logic                 better;
    logic                 more_to_read;
    logic                 load_ok;
    logic [31:0]          idx_wide;
    logic [31:0]          best_wide;
    logic [31:0]          rem_wide;
    logic [31:0]          load_wide;
    logic [31:0]          active_wide;
    logic [CW-1:0]        n_next;

    out_t res_reg;
    out_t out_reg;
    logic out_valid_reg;

    assign size_wide    = 32'(in_data.size_kb);
    assign idx_wide     = 32'(idx_reg);
    assign best_wide    = 32'(best_reg);
    assign rem_wide     = 32'(best_rem_reg);
    assign load_wide    = 32'(size_reg);
    assign active_wide  = 32'(active_segments);
    assign load_ok      = idx_wide < 32'(NUM_SEGMENTS);
    assign more_to_read = scan_i_reg < n_reg;

    always_comb
    begin
        if (active_wide > 32'(NUM_SEGMENTS))
        begin
            n_next = CW'(NUM_SEGMENTS);
        end
        else
        begin
            n_next = active_wide[CW-1:0];
        end
    end

    // store access
    assign rd_en   = uop.scan_step && more_to_read;
    assign rd_addr = scan_i_reg[IW-1:0];
    assign wr_en   = (uop.load_wr && load_ok) || (uop.alloc_wb && found_reg);
    assign wr_addr = uop.load_wr ? idx_wide[IW-1:0] : best_reg;
    assign wr_data = uop.load_wr ? size_reg : best_rem_reg;

    bfsa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_SEGMENTS),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // best-fit compare
    assign free_kb = rd_vld_reg ? rd_data : '0;
    assign rem_kb  = free_kb - size_reg;
    assign better  = cmp_vld_reg && (free_kb >= size_reg)
                     && (!found_reg || (rem_kb < best_rem_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_vld_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (uop.load_wr && load_ok)
            begin
                seg_vld_reg[idx_wide[IW-1:0]] <= 1'b1;
            end
            if (uop.scan_init)
            begin
                cmp_vld_reg <= 1'b0;
            end
            else if (uop.scan_step)
            begin
                cmp_vld_reg <= more_to_read;
            end
            if (uop.emit && !status.out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (uop.in_take && in_valid)
        begin
            op_reg   <= in_data.operation;
            idx_reg  <= in_data.segment_index;
            size_reg <= size_wide[SIZE_BITS-1:0];
        end
        if (rd_en)
        begin
            rd_vld_reg  <= seg_vld_reg[rd_addr];
            cmp_idx_reg <= rd_addr;
            scan_i_reg  <= scan_i_reg + 1'b1;
        end
        if (uop.scan_init)
        begin
            scan_i_reg <= '0;
            n_reg      <= n_next;
            found_reg  <= 1'b0;
        end
        else if (uop.scan_step && better)
        begin
            found_reg    <= 1'b1;
            best_reg     <= cmp_idx_reg;
            best_rem_reg <= rem_kb;
        end
        if (uop.load_wr)
        begin
            res_reg.granted        <= load_ok;
            res_reg.chosen_segment <= idx_reg;
            res_reg.remaining_kb   <= load_ok ? load_wide[15:0] : 16'd0;
        end
        if (uop.alloc_wb)
        begin
            res_reg.granted        <= found_reg;
            res_reg.chosen_segment <= found_reg ? best_wide[3:0] : 4'd0;
            res_reg.remaining_kb   <= found_reg ? rem_wide[15:0] : 16'd0;
        end
        if (uop.emit && !status.out_busy)
        begin
            out_reg <= res_reg;
        end
    end

    assign status.in_valid  = in_valid;
    assign status.is_load   = (op_reg == OP_LOAD);
    assign status.scan_busy = more_to_read || cmp_vld_reg;
    assign status.out_busy  = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: design/best_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_top
// Best-fit allocator over a fixed set of memory segments.
// ----------------------------------------------------------------------------
// One item is handled at a time under a small microcoded sequencer. A load
// beat passes fetch, dispatch, load write and emit; an allocate beat passes
// fetch, dispatch, scan, write-back and emit, the scan reading n segments, n
// being the active segment count limited to NUM_SEGMENTS, one segment per
// cycle through the single read port of the free-space RAM. Free space is zero
// after reset through per-segment valid flags, so no clearing pass is needed. A
// finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_top #(
    parameter int NUM_SEGMENTS = 16,
    parameter int SIZE_BITS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bfsa_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output bfsa_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [4:0]     cfg_data
);
    import bfsa_pkg::*;

    uop_t                uop;
    status_t             status;
    logic [CFG_BITS-1:0] active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = !uop.in_take;

    bfsa_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uop    (uop)
    );

    bfsa_datapath #(
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .SIZE_BITS    (SIZE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .uop             (uop),
        .status          (status),
        .active_segments (active_reg),
        .in_valid        (in_valid),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data)
    );

endmodule
